// ===== src/infix_to_postfix_converter_defines.svh =====
// Assertion macros shared by the checker.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Clocked check, quiet while reset is held.
`define ITP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ITP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/itp_pkg.sv =====
package itp_pkg;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW,
    OP_LPAREN
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_UNM_CLOSE,
    ST_UNM_OPEN
  } status_t;

  typedef enum logic [2:0] {
    K_FLUSH,
    K_SPACE,
    K_OPER,
    K_LPAREN,
    K_RPAREN,
    K_OPERAND
  } kind_t;

  typedef enum logic [1:0] {
    EMIT_TOP,
    EMIT_CHAR,
    EMIT_STATUS
  } emit_sel_t;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_t emit_sel;
    status_t   emit_status;
    logic      emit_last;
    logic      set_open;
  } itp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  has_sec;
    logic  top_lp;
    logic  top_pops;
    logic  sec_lp;
    logic  sec_pops;
    logic  open_err;
    logic  out_free;
  } itp_sts_t;

  function automatic logic [7:0] code_char(input op_code_t c);
    logic [7:0] r;
    case (c)
      OP_ADD:    r = CH_PLUS;
      OP_SUB:    r = CH_MINUS;
      OP_MUL:    r = CH_STAR;
      OP_DIV:    r = CH_SLASH;
      OP_POW:    r = CH_CARET;
      OP_LPAREN: r = CH_LP;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] op_prec(input op_code_t c);
    logic [2:0] r;
    case (c)
      OP_POW:  r = 3'd4;
      OP_MUL:  r = 3'd3;
      OP_DIV:  r = 3'd3;
      OP_ADD:  r = 3'd2;
      OP_SUB:  r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic op_code_t ch_code(input logic [7:0] ch);
    op_code_t r;
    case (ch)
      CH_PLUS:  r = OP_ADD;
      CH_MINUS: r = OP_SUB;
      CH_STAR:  r = OP_MUL;
      CH_SLASH: r = OP_DIV;
      CH_CARET: r = OP_POW;
      default:  r = OP_LPAREN;
    endcase
    return r;
  endfunction

  function automatic kind_t classify(input logic [7:0] ch, input logic flush);
    kind_t r;
    if (flush) begin
      r = K_FLUSH;
    end else begin
      case (ch)
        CH_SPACE: r = K_SPACE;
        CH_PLUS:  r = K_OPER;
        CH_MINUS: r = K_OPER;
        CH_STAR:  r = K_OPER;
        CH_SLASH: r = K_OPER;
        CH_CARET: r = K_OPER;
        CH_LP:    r = K_LPAREN;
        CH_RP:    r = K_RPAREN;
        default:  r = K_OPERAND;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/infix_to_postfix_converter.sv =====
// Channel  Direction  tdata               tuser                          tlast
// in_      slave      [7:0] character     -                              end of expression
// out_     master     [7:0] out character [0] has_char, [2:1] status     last result of item
//
// One item is taken, then worked on alone: a beat that makes no stack pop is
// accepted, then decided. Each popped operator, and each '(' dropped by a flush,
// adds a step, set by the single stack read port that refills the second-from-top
// register. A stalled output holds the work loop; the next beat is accepted in the
// cycle after the item's last step. Reset clears the state, the open-bracket flag,
// the stack count and the output valid; stack entries need none.
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // flush
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_ch
  output logic [2:0] out_tuser,  // [0] has_char, [2:1] status
  output logic       out_tlast   // last
);

  itp_cmd_t cmd;
  itp_sts_t sts;

  // Sequence the item: accept, then step pops, pushes and emits.
  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the operator stack, the item and the output register.
  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_tdata),
    .in_flush   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/itp_datapath.sv =====
module itp_datapath
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_ch,
  input  logic       in_flush,
  input  itp_cmd_t   cmd,
  output itp_sts_t   sts,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [2:0] out_tuser,
  output logic       out_tlast
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  op_code_t        stack_mem [STACK_DEPTH];
  logic [CW-1:0]   count_r, count_nxt;
  op_code_t        top_r, sec_r;
  kind_t           kind_r;
  op_code_t        code_r;
  logic [7:0]      ch_r;
  logic            open_r;
  logic [IW-1:0]   rd_addr;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r;
  logic [2:0]      out_user_r;
  logic            out_last_r;
  logic [7:0]      emit_ch;
  logic            emit_has;
  status_t         emit_st;

  // Latch the item and decode it once.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= classify(in_ch, in_flush);
      code_r <= ch_code(in_ch);
      ch_r   <= in_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (cmd.load) begin
      open_r <= 1'b0;
    end else if (cmd.set_open) begin
      open_r <= 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rd_addr = IW'(count_r - CW'(3));

  // Keep the two upper entries in registers; refill the second from memory.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[count_r[IW-1:0]] <= code_r;
      top_r <= code_r;
      sec_r <= top_r;
    end else if (cmd.pop) begin
      top_r <= sec_r;
      if (count_r > CW'(2)) begin
        sec_r <= stack_mem[rd_addr];
      end
    end
  end

  always_comb begin
    sts.kind     = kind_r;
    sts.empty    = (count_r == '0);
    sts.full     = (count_r == CW'(STACK_DEPTH));
    sts.has_sec  = (count_r > CW'(1));
    sts.top_lp   = (top_r == OP_LPAREN);
    sts.top_pops = (top_r != OP_LPAREN) && (op_prec(top_r) >= op_prec(code_r));
    sts.sec_lp   = (sec_r == OP_LPAREN);
    sts.sec_pops = (sec_r != OP_LPAREN) && (op_prec(sec_r) >= op_prec(code_r));
    sts.open_err = open_r;
    sts.out_free = !out_valid_r || out_tready;
  end

  always_comb begin
    case (cmd.emit_sel)
      EMIT_TOP: begin
        emit_ch  = code_char(top_r);
        emit_has = 1'b1;
        emit_st  = ST_OK;
      end
      EMIT_CHAR: begin
        emit_ch  = ch_r;
        emit_has = 1'b1;
        emit_st  = ST_OK;
      end
      default: begin
        emit_ch  = 8'h00;
        emit_has = 1'b0;
        emit_st  = cmd.emit_status;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= emit_ch;
      out_user_r <= {emit_st, emit_has};
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/itp_ctrl.sv =====
module itp_ctrl
  import itp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  itp_sts_t sts,
  output itp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        case (sts.kind)
          K_SPACE: begin
            state_nxt = S_IDLE;
          end
          K_OPERAND: begin
            if (sts.out_free) state_nxt = S_IDLE;
          end
          K_LPAREN: begin
            if (!sts.full || sts.out_free) state_nxt = S_IDLE;
          end
          K_OPER: begin
            if (!(!sts.empty && sts.top_pops) && (!sts.full || sts.out_free)) begin
              state_nxt = S_IDLE;
            end
          end
          K_RPAREN: begin
            if ((sts.empty && sts.out_free) || (!sts.empty && sts.top_lp)) begin
              state_nxt = S_IDLE;
            end
          end
          K_FLUSH: begin
            if (sts.empty && sts.out_free) state_nxt = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.emit_sel    = EMIT_STATUS;
    cmd.emit_status = ST_OK;
    cmd.load        = in_tvalid && in_tready;
    case (state_r)
      S_WORK: begin
        case (sts.kind)
          K_OPERAND: begin
            cmd.emit      = sts.out_free;
            cmd.emit_sel  = EMIT_CHAR;
            cmd.emit_last = 1'b1;
          end
          K_LPAREN: begin
            if (!sts.full) begin
              cmd.push = 1'b1;
            end else begin
              cmd.emit        = sts.out_free;
              cmd.emit_status = ST_OVERFLOW;
              cmd.emit_last   = 1'b1;
            end
          end
          K_OPER: begin
            if (!sts.empty && sts.top_pops) begin
              cmd.emit      = sts.out_free;
              cmd.pop       = sts.out_free;
              cmd.emit_sel  = EMIT_TOP;
              cmd.emit_last = !(sts.has_sec && sts.sec_pops);
            end else if (!sts.full) begin
              cmd.push = 1'b1;
            end else begin
              cmd.emit        = sts.out_free;
              cmd.emit_status = ST_OVERFLOW;
              cmd.emit_last   = 1'b1;
            end
          end
          K_RPAREN: begin
            if (sts.empty) begin
              cmd.emit        = sts.out_free;
              cmd.emit_status = ST_UNM_CLOSE;
              cmd.emit_last   = 1'b1;
            end else if (sts.top_lp) begin
              cmd.pop = 1'b1;
            end else begin
              cmd.emit      = sts.out_free;
              cmd.pop       = sts.out_free;
              cmd.emit_sel  = EMIT_TOP;
              cmd.emit_last = sts.has_sec && sts.sec_lp;
            end
          end
          K_FLUSH: begin
            if (sts.empty) begin
              cmd.emit        = sts.out_free;
              cmd.emit_status = sts.open_err ? ST_UNM_OPEN : ST_OK;
              cmd.emit_last   = 1'b1;
            end else if (sts.top_lp) begin
              cmd.pop      = 1'b1;
              cmd.set_open = 1'b1;
            end else begin
              cmd.emit     = sts.out_free;
              cmd.pop      = sts.out_free;
              cmd.emit_sel = EMIT_TOP;
            end
          end
          default: begin
            cmd.emit = 1'b0;
          end
        endcase
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/infix_to_postfix_converter_checker.sv =====
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  `ITP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output beat changed while stalled")
  `ITP_ASSERT(a_status_last, out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 8'h00), "status-only beat not terminal or carries data")
  `ITP_ASSERT(a_char_ok, out_tvalid && out_tuser[0] |-> (out_tuser[2:1] == 2'b00), "character beat carries an error status")
  `ITP_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "second beat taken while an item is in work")
  `ITP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind infix_to_postfix_converter infix_to_postfix_converter_checker u_checker (.*);
